/* hdl/accel_orient_zero_blend_core_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ACCEL_ORIENT_ZERO_BLEND_CORE_MACROS_SVH
`define ACCEL_ORIENT_ZERO_BLEND_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define AOZB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define AOZB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/aozb_pkg.sv */
`default_nettype none
package aozb_pkg;

    localparam int NUM_ORIENTATIONS = 24;
    localparam logic [4:0] NUM_ORIENT_5 = 5'd24;

    // Weight that passes a path through unchanged.
    localparam logic signed [7:0] PCT_FULL = 8'sd100;

    // ceil(2^29 / 100): exact floor(m / 100) for m below 2^22.
    localparam int RECIP_SHIFT = 29;
    localparam logic [22:0] RECIP_100 = 23'd5368710;

    typedef enum logic [2:0] {
        CFG_ORIENT_FIRST  = 3'd0,
        CFG_ORIENT_SECOND = 3'd1,
        CFG_DUAL_ORIENT   = 3'd2,
        CFG_ZEROS_FIRST   = 3'd3,
        CFG_ZEROS_SECOND  = 3'd4,
        CFG_INV_CAL_FLAGS = 3'd5
    } cfg_index_t;

    // Sensor axis feeding each board axis, packed {yaw, pitch, roll}.
    localparam logic [5:0] MAP_A = {2'd2, 2'd1, 2'd0};
    localparam logic [5:0] MAP_B = {2'd2, 2'd0, 2'd1};
    localparam logic [5:0] MAP_C = {2'd1, 2'd2, 2'd0};
    localparam logic [5:0] MAP_D = {2'd0, 2'd2, 2'd1};
    localparam logic [5:0] MAP_E = {2'd1, 2'd0, 2'd2};
    localparam logic [5:0] MAP_F = {2'd0, 2'd1, 2'd2};

    localparam logic [5:0] AXIS_MAP [NUM_ORIENTATIONS] = '{
        MAP_A, MAP_B, MAP_A, MAP_B,
        MAP_C, MAP_D, MAP_C, MAP_D,
        MAP_A, MAP_B, MAP_A, MAP_B,
        MAP_C, MAP_D, MAP_C, MAP_D,
        MAP_E, MAP_F, MAP_E, MAP_F,
        MAP_E, MAP_F, MAP_E, MAP_F
    };

    // Negate flags per board axis, packed {yaw, pitch, roll}.
    localparam logic [2:0] AXIS_NEG [NUM_ORIENTATIONS] = '{
        3'b011, 3'b010, 3'b000, 3'b001,
        3'b111, 3'b110, 3'b010, 3'b011,
        3'b110, 3'b111, 3'b101, 3'b100,
        3'b100, 3'b101, 3'b001, 3'b000,
        3'b110, 3'b100, 3'b000, 3'b010,
        3'b101, 3'b111, 3'b011, 3'b001
    };

    typedef struct packed {
        logic load_a;
        logic load_b;
    } stage_ctl_t;

endpackage
`default_nettype wire

/* hdl/aozb_path.sv */
`default_nettype none
module aozb_path (
    input  wire logic signed [15:0] raw [3],
    input  wire logic        [4:0]  orient,
    input  wire logic        [63:0] zeros,
    input  wire logic               inv_done,
    input  wire logic signed [15:0] smooth,
    output logic signed      [15:0] axes [3],
    output logic signed      [17:0] vert
);
    import aozb_pkg::*;

    logic [4:0]         oi;
    logic [5:0]         map;
    logic [2:0]         neg;
    logic signed [15:0] norm_z;
    logic signed [15:0] half_diff;
    logic signed [15:0] yaw_zero;

    assign oi        = (orient < NUM_ORIENT_5) ? orient : 5'd0;
    assign map       = AXIS_MAP[oi];
    assign neg       = AXIS_NEG[oi];
    assign norm_z    = zeros[47:32];
    assign half_diff = zeros[63:48];
    assign yaw_zero  = inv_done ? (norm_z - half_diff) : 16'sd0;

    always_comb
    begin
        logic signed [15:0] v;
        logic signed [9:0]  s;
        logic signed [15:0] z;
        logic signed [16:0] d;
        logic signed [15:0] t;
        for (int i = 0; i < 2; i++)
        begin
            v = raw[map[2*i +: 2]];
            s = v[15:6];
            z = zeros[16*i +: 16];
            d = {{7{s[9]}}, s} - {z[15], z};
            axes[i] = neg[i] ? -d[15:0] : d[15:0];
        end
        // Yaw: polarity first, then the zero.
        v = raw[map[5:4]];
        s = v[15:6];
        t = {{6{s[9]}}, s};
        axes[2] = (neg[2] ? -t : t) - yaw_zero;
    end

    assign vert = {{2{smooth[15]}}, smooth} + {{2{norm_z[15]}}, norm_z}
                - {{2{yaw_zero[15]}}, yaw_zero};

endmodule
`default_nettype wire

/* hdl/aozb_scale.sv */
`default_nettype none
module aozb_scale (
    input  wire logic                    clk,
    input  wire aozb_pkg::stage_ctl_t    ctl,
    input  wire logic signed [15:0]      value,
    input  wire logic signed [7:0]       weight,
    output logic signed      [15:0]      scaled
);
    import aozb_pkg::*;

    logic signed [23:0] prod;
    logic        [21:0] mag_next;
    logic        [21:0] mag_reg;
    logic               neg_reg;
    logic        [44:0] recip_prod;
    logic        [15:0] quot;
    logic signed [15:0] scaled_next;
    logic signed [15:0] scaled_reg;

    // Stage A: weight product, split into sign and magnitude.
    assign prod     = value * weight;
    assign mag_next = prod[23] ? 22'(-prod) : prod[21:0];

    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            mag_reg <= mag_next;
            neg_reg <= prod[23];
        end
    end

    // Stage B: divide by one hundred through the reciprocal, truncate toward zero.
    assign recip_prod  = {23'd0, mag_reg} * {22'd0, RECIP_100};
    assign quot        = recip_prod[RECIP_SHIFT +: 16];
    assign scaled_next = neg_reg ? -quot : quot;

    always_ff @(posedge clk)
    begin
        if (ctl.load_b)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule
`default_nettype wire

/* hdl/accel_orient_zero_blend_core.sv */
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+-----------------------------------------------
// sample   | sample_valid / sample_stall   | raw_x, raw_y, raw_z, blend_percent, smoothed_vert
// result   | result_valid / result_stall   | acc_roll, acc_pitch, acc_yaw, acc_vertical
// config   | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item per cycle while result_stall is low; items pass stages 1 to 3, then the output register.
// The depth comes from the two multiplies per lane (weight, then reciprocal).
// rst_n clears valid bits and configuration; data registers are not reset.
// Stalls back up stage by stage; empty stages still fill under a stall.
// cfg_ready is always high.
`default_nettype none
module accel_orient_zero_blend_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic        [15:0] raw_x,
    input  wire logic        [15:0] raw_y,
    input  wire logic        [15:0] raw_z,
    input  wire logic        [6:0]  blend_percent,
    input  wire logic signed [15:0] smoothed_vert,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed      [15:0] acc_roll,
    output logic signed      [15:0] acc_pitch,
    output logic signed      [15:0] acc_yaw,
    output logic signed      [16:0] acc_vertical,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [63:0] cfg_data
);
    import aozb_pkg::*;

    localparam int NUM_LANES = 8;

    // Configuration registers.
    logic [4:0]  orient_first_reg,  orient_first_next;
    logic [4:0]  orient_second_reg, orient_second_next;
    logic        dual_orient_reg,   dual_orient_next;
    logic [63:0] zeros_first_reg,   zeros_first_next;
    logic [63:0] zeros_second_reg,  zeros_second_next;
    logic [1:0]  inv_flags_reg,     inv_flags_next;

    // Stage valid bits and advance terms.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;
    logic adv_s1, adv_s2, adv_s3, adv_out;

    logic signed [15:0] raw [3];
    logic signed [15:0] axes1 [3];
    logic signed [15:0] axes2 [3];
    logic signed [17:0] vert1;
    logic signed [17:0] vert2;

    // Stage 1 data: per-path values, weights, single-mode vertical.
    logic signed [15:0] s1_lane_reg [NUM_LANES];
    logic signed [15:0] s1_lane_next [NUM_LANES];
    logic signed [7:0]  s1_w1_reg, s1_w1_next;
    logic signed [7:0]  s1_w2_reg, s1_w2_next;
    logic signed [16:0] s1_vert_reg;
    logic signed [16:0] s2_vert_reg;
    logic signed [16:0] s3_vert_reg;

    logic signed [15:0] lane_scaled [NUM_LANES];
    stage_ctl_t         lane_ctl;

    logic signed [15:0] roll_next, pitch_next, yaw_next;
    logic signed [16:0] vert_next;
    logic signed [15:0] acc_roll_reg, acc_pitch_reg, acc_yaw_reg;
    logic signed [16:0] acc_vertical_reg;

    // ---------------------------------------------------------------
    // Configuration port: index outside the list is dropped.
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        orient_first_next  = orient_first_reg;
        orient_second_next = orient_second_reg;
        dual_orient_next   = dual_orient_reg;
        zeros_first_next   = zeros_first_reg;
        zeros_second_next  = zeros_second_reg;
        inv_flags_next     = inv_flags_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORIENT_FIRST:  orient_first_next  = cfg_data[4:0];
                CFG_ORIENT_SECOND: orient_second_next = cfg_data[4:0];
                CFG_DUAL_ORIENT:   dual_orient_next   = cfg_data[0];
                CFG_ZEROS_FIRST:   zeros_first_next   = cfg_data;
                CFG_ZEROS_SECOND:  zeros_second_next  = cfg_data;
                CFG_INV_CAL_FLAGS: inv_flags_next     = cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_first_reg  <= '0;
            orient_second_reg <= '0;
            dual_orient_reg   <= 1'b0;
            zeros_first_reg   <= '0;
            zeros_second_reg  <= '0;
            inv_flags_reg     <= '0;
        end
        else
        begin
            orient_first_reg  <= orient_first_next;
            orient_second_reg <= orient_second_next;
            dual_orient_reg   <= dual_orient_next;
            zeros_first_reg   <= zeros_first_next;
            zeros_second_reg  <= zeros_second_next;
            inv_flags_reg     <= inv_flags_next;
        end
    end

    // ---------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor
    // moves on, so bubbles collapse and a full pipe runs every cycle while result_stall is low.
    // ---------------------------------------------------------------
    assign adv_out      = !out_valid_reg || !result_stall;
    assign adv_s3       = !s3_valid_reg || adv_out;
    assign adv_s2       = !s2_valid_reg || adv_s3;
    assign adv_s1       = !s1_valid_reg || adv_s2;
    assign sample_stall = !adv_s1;

    assign s1_valid_next  = adv_s1  ? sample_valid : s1_valid_reg;
    assign s2_valid_next  = adv_s2  ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = adv_s3  ? s2_valid_reg : s3_valid_reg;
    assign out_valid_next = adv_out ? s3_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: orientation mapping and zeroing for both positions.
    // The second sensor axis is negated with 16-bit wrap.
    // ---------------------------------------------------------------
    assign raw[0] = raw_x;
    assign raw[1] = -raw_y;
    assign raw[2] = raw_z;

    aozb_path u_path_first (
        .raw      (raw),
        .orient   (orient_first_reg),
        .zeros    (zeros_first_reg),
        .inv_done (inv_flags_reg[0]),
        .smooth   (smoothed_vert),
        .axes     (axes1),
        .vert     (vert1)
    );

    aozb_path u_path_second (
        .raw      (raw),
        .orient   (orient_second_reg),
        .zeros    (zeros_second_reg),
        .inv_done (inv_flags_reg[1]),
        .smooth   (smoothed_vert),
        .axes     (axes2),
        .vert     (vert2)
    );

    // Lanes 0-3: first path (roll, pitch, yaw, vertical); lanes 4-7: second.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_lane_next[i]     = axes1[i];
            s1_lane_next[i + 4] = axes2[i];
        end
        s1_lane_next[3] = vert1[15:0];
        s1_lane_next[7] = vert2[15:0];
    end

    // Single mode runs the same lanes with weights 0 and 100, which
    // reproduce the second path exactly on the three axes.
    assign s1_w1_next = dual_orient_reg ? (PCT_FULL - $signed({1'b0, blend_percent})) : 8'sd0;
    assign s1_w2_next = dual_orient_reg ? $signed({1'b0, blend_percent}) : PCT_FULL;

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_lane_reg <= s1_lane_next;
            s1_w1_reg   <= s1_w1_next;
            s1_w2_reg   <= s1_w2_next;
            s1_vert_reg <= vert2[16:0];
        end
    end

    // ---------------------------------------------------------------
    // Stages 2 and 3: percent scaling lanes.
    // ---------------------------------------------------------------
    assign lane_ctl.load_a = adv_s2;
    assign lane_ctl.load_b = adv_s3;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        aozb_scale u_scale (
            .clk    (clk),
            .ctl    (lane_ctl),
            .value  (s1_lane_reg[g]),
            .weight ((g < NUM_LANES / 2) ? s1_w1_reg : s1_w2_reg),
            .scaled (lane_scaled[g])
        );
    end

    // Carry the unwrapped single-mode vertical alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (adv_s2)
        begin
            s2_vert_reg <= s1_vert_reg;
        end
        if (adv_s3)
        begin
            s3_vert_reg <= s2_vert_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: blend sums into the output register.
    // ---------------------------------------------------------------
    assign roll_next  = lane_scaled[0] + lane_scaled[4];
    assign pitch_next = lane_scaled[1] + lane_scaled[5];
    assign yaw_next   = lane_scaled[2] + lane_scaled[6];
    assign vert_next  = dual_orient_reg
                      ? ({lane_scaled[3][15], lane_scaled[3]}
                         + {lane_scaled[7][15], lane_scaled[7]})
                      : s3_vert_reg;

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            acc_roll_reg     <= roll_next;
            acc_pitch_reg    <= pitch_next;
            acc_yaw_reg      <= yaw_next;
            acc_vertical_reg <= vert_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign acc_roll     = acc_roll_reg;
    assign acc_pitch    = acc_pitch_reg;
    assign acc_yaw      = acc_yaw_reg;
    assign acc_vertical = acc_vertical_reg;

endmodule
`default_nettype wire

/* hdl/aozb_checker.sv */
`default_nettype none
`include "accel_orient_zero_blend_core_macros.svh"
module aozb_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    input  wire logic               sample_stall,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire logic signed [15:0] acc_roll,
    input  wire logic signed [15:0] acc_pitch,
    input  wire logic signed [15:0] acc_yaw,
    input  wire logic signed [16:0] acc_vertical,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready
);

    // Hold a stalled result and its payload.
    `AOZB_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(acc_roll) && $stable(acc_pitch) && $stable(acc_yaw) && $stable(acc_vertical), "stalled result changed")

    // With the output empty every stage can advance, so no input stall.
    `AOZB_ASSERT_SAME(a_no_stall_when_empty, !result_valid, !sample_stall, "input stalled while output empty")

    // An accepted item passes stages 1 to 3 and reaches the output register when nothing stalls.
    `AOZB_ASSERT_NEXT(a_latency, (sample_valid && !sample_stall) ##1 !result_stall ##1 !result_stall ##1 !result_stall, result_valid, "item did not reach output in four cycles")

    // Take configuration writes at any time.
    `AOZB_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind accel_orient_zero_blend_core aozb_checker u_aozb_checker (.*);
`default_nettype wire
